// ===== design/kct_pkg.sv =====
// Package for the keyed count table: field widths, request codes,
// and the types passed between the top level and its cells.
// No dependencies.
`default_nettype none

package kct_pkg;

  localparam int unsigned REQ_W  = 4;
  localparam int unsigned KEY_W  = 16;
  localparam int unsigned DATA_W = 16;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned USED_W = 5;

  localparam logic [REQ_W-1:0] REQ_ADD      = 4'd0;
  localparam logic [REQ_W-1:0] REQ_RM_KEY   = 4'd1;
  localparam logic [REQ_W-1:0] REQ_RM_POS   = 4'd2;
  localparam logic [REQ_W-1:0] REQ_GET_KEY  = 4'd3;
  localparam logic [REQ_W-1:0] REQ_GET_POS  = 4'd4;
  localparam logic [REQ_W-1:0] REQ_FIND     = 4'd5;
  localparam logic [REQ_W-1:0] REQ_INCREASE = 4'd6;
  localparam logic [REQ_W-1:0] REQ_DECREASE = 4'd7;
  localparam logic [REQ_W-1:0] REQ_CLEAR    = 4'd8;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SET,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_e;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] count;
  } entry_t;

  // lookup strobe, broadcast to every cell on an accepted beat
  typedef struct packed {
    logic              en;
    logic              key_mode;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] amount;
    logic [POS_W-1:0]  position;
  } look_t;

  // update command, broadcast in the apply cycle
  typedef struct packed {
    cell_op_e          op;
    logic [DATA_W-1:0] new_count;
  } ctl_t;

  // per-cell lookup results
  typedef struct packed {
    logic sel;   // this cell is the target
    logic aft;   // this cell is at or after the target
    logic ge;    // count >= amount
    logic zero;  // count == amount
  } stat_t;

endpackage

`default_nettype wire

// ===== design/kct_cell.sv =====
// One table position: holds a key/count pair, compares on lookup,
// shifts with its neighbors on insert/remove. Uses kct_pkg.
`default_nettype none

module kct_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire kct_pkg::look_t  look_i,
  input  wire kct_pkg::ctl_t   ctl_i,
  input  wire                  valid_i,
  input  wire                  seen_i,
  output logic                 seen_o,
  input  wire kct_pkg::entry_t left_i,
  input  wire kct_pkg::entry_t right_i,
  output kct_pkg::entry_t      ent_o,
  output kct_pkg::stat_t       stat_o
);

  kct_pkg::entry_t ent_q;
  kct_pkg::stat_t  stat_q, stat_d;
  logic            match, pos_eq, pos_ge;

  assign match  = valid_i && (ent_q.key == look_i.key);
  assign seen_o = seen_i | match;
  assign pos_eq = (32'(look_i.position) == IDX);
  assign pos_ge = (IDX >= 32'(look_i.position));

  always_comb begin
    stat_d.sel  = look_i.key_mode ? (match & ~seen_i) : (pos_eq & valid_i);
    stat_d.aft  = look_i.key_mode ? seen_o : pos_ge;
    stat_d.ge   = ent_q.count >= look_i.amount;
    stat_d.zero = ent_q.count == look_i.amount;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_q <= '0;
    end else if (look_i.en) begin
      stat_q <= stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      kct_pkg::CELL_SET: begin
        if (stat_q.sel) ent_q.count <= ctl_i.new_count;
      end
      kct_pkg::CELL_INSERT: begin
        ent_q <= left_i;
      end
      kct_pkg::CELL_REMOVE: begin
        if (stat_q.aft) ent_q <= right_i;
      end
      default: begin
        ent_q <= ent_q;
      end
    endcase
  end

  assign ent_o  = ent_q;
  assign stat_o = stat_q;

endmodule

`default_nettype wire

// ===== design/keyed_count_table_top.sv =====
// Keyed count table top level: request handling, table occupancy and
// the result register around a chain of kct_cell. Uses kct_pkg, kct_cell.
//
//   channel | dir | handshake                  | beat fields
//   --------+-----+----------------------------+----------------------------------------
//   in      | in  | in_valid_i / in_ready_o    | req_type_i item_key_i amount_i position_i
//   out     | out | out_valid_o / out_ready_i  | ok_o result_key_o result_count_o
//           |     |                            | entries_used_o
//
// On the accept edge every cell compares its key (and its position) against
// the beat and latches hit flags; in the apply state that follows, the hit
// entry is gathered, the decision is made and the cells update in place or
// shift by one position toward their neighbors.
// Reset empties the table (count to zero) at once; entries are never read
// before they are written, so there is no clearing pass.
// A finished beat sits in the output register; a new request is accepted
// meanwhile, and its apply cycle holds until the output register is free.
`default_nettype none

module keyed_count_table_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [3:0]  req_type_i,
  input  wire  [15:0] item_key_i,
  input  wire  [15:0] amount_i,
  input  wire  [3:0]  position_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic        ok_o,
  output logic [15:0] result_key_o,
  output logic [15:0] result_count_o,
  output logic [4:0]  entries_used_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } state_e;

  state_e state_q;

  // request held through the apply cycle
  logic [kct_pkg::REQ_W-1:0]  req_type_q;
  logic [kct_pkg::KEY_W-1:0]  key_q;
  logic [kct_pkg::DATA_W-1:0] amount_q;

  logic [CNT_W-1:0] used_q, used_d;

  logic                        out_valid_q, ok_q, ok_d;
  logic [kct_pkg::KEY_W-1:0]   rkey_q, rkey_d;
  logic [kct_pkg::DATA_W-1:0]  rcnt_q, rcnt_d;
  logic [kct_pkg::USED_W-1:0]  eu_q;
  logic [CNT_W+kct_pkg::USED_W-1:0] used_ext;

  logic accept, commit;

  kct_pkg::look_t  look;
  kct_pkg::ctl_t   ctl;
  kct_pkg::cell_op_e op_sel;
  kct_pkg::entry_t ent   [CAPACITY];
  kct_pkg::entry_t left  [CAPACITY];
  kct_pkg::entry_t right [CAPACITY];
  kct_pkg::stat_t  stat  [CAPACITY];
  logic [CAPACITY-1:0] valid, sel_vec;
  logic [CAPACITY:0]   seen;

  // gathered view of the target cell
  logic                        found, g_ge, g_zero;
  logic [kct_pkg::KEY_W-1:0]   g_key;
  logic [kct_pkg::DATA_W-1:0]  g_cnt;
  logic [kct_pkg::DATA_W:0]    sum;
  logic [kct_pkg::DATA_W-1:0]  sat_sum, diff;
  logic                        full;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign commit     = (state_q == ST_APPLY) && (!out_valid_q || out_ready_i);

  // ---- lookup broadcast ----
  always_comb begin
    look.en       = accept;
    look.key_mode = !((req_type_i == kct_pkg::REQ_RM_POS) ||
                      (req_type_i == kct_pkg::REQ_GET_POS));
    look.key      = item_key_i;
    look.amount   = amount_i;
    look.position = position_i;
  end

  // ---- cell chain ----
  assign seen[0] = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    assign valid[g]   = CNT_W'(g) < used_q;
    assign sel_vec[g] = stat[g].sel;

    if (g == 0) begin : g_head
      assign left[g] = '{key: key_q, count: amount_q};
    end else begin : g_mid
      assign left[g] = ent[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right[g] = '0;
    end else begin : g_body
      assign right[g] = ent[g+1];
    end

    kct_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .look_i  (look),
      .ctl_i   (ctl),
      .valid_i (valid[g]),
      .seen_i  (seen[g]),
      .seen_o  (seen[g+1]),
      .left_i  (left[g]),
      .right_i (right[g]),
      .ent_o   (ent[g]),
      .stat_o  (stat[g])
    );
  end

  // ---- gather target entry (at most one cell selected) ----
  always_comb begin
    found  = 1'b0;
    g_ge   = 1'b0;
    g_zero = 1'b0;
    g_key  = '0;
    g_cnt  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (stat[i].sel) begin
        found  = 1'b1;
        g_ge   = g_ge | stat[i].ge;
        g_zero = g_zero | stat[i].zero;
        g_key  = g_key | ent[i].key;
        g_cnt  = g_cnt | ent[i].count;
      end
    end
  end

  assign sum     = {1'b0, g_cnt} + {1'b0, amount_q};
  assign sat_sum = sum[kct_pkg::DATA_W] ? '1 : sum[kct_pkg::DATA_W-1:0];
  assign diff    = g_cnt - amount_q;
  assign full    = (used_q == CNT_W'(CAPACITY));

  // ---- apply decision ----
  always_comb begin
    op_sel = kct_pkg::CELL_HOLD;
    ctl.new_count = sat_sum;
    ok_d   = 1'b0;
    rkey_d = '0;
    rcnt_d = '0;
    used_d = used_q;
    case (req_type_q)
      kct_pkg::REQ_ADD: begin
        if (!full) begin
          ok_d = 1'b1;
          if (found) begin
            op_sel = kct_pkg::CELL_SET;
          end else begin
            op_sel = kct_pkg::CELL_INSERT;
            used_d = used_q + CNT_W'(1);
          end
        end
      end
      kct_pkg::REQ_RM_KEY, kct_pkg::REQ_RM_POS: begin
        if (found) begin
          ok_d   = 1'b1;
          op_sel = kct_pkg::CELL_REMOVE;
          used_d = used_q - CNT_W'(1);
        end
      end
      kct_pkg::REQ_GET_KEY, kct_pkg::REQ_GET_POS: begin
        ok_d   = found;
        rkey_d = g_key;
        rcnt_d = g_cnt;
      end
      kct_pkg::REQ_FIND: begin
        ok_d = found;
      end
      kct_pkg::REQ_INCREASE: begin
        if (found) begin
          ok_d   = 1'b1;
          op_sel = kct_pkg::CELL_SET;
        end
      end
      kct_pkg::REQ_DECREASE: begin
        ctl.new_count = diff;
        if (found && g_ge) begin
          ok_d = 1'b1;
          if (g_zero) begin
            op_sel = kct_pkg::CELL_REMOVE;
            used_d = used_q - CNT_W'(1);
          end else begin
            op_sel = kct_pkg::CELL_SET;
          end
        end
      end
      kct_pkg::REQ_CLEAR: begin
        ok_d   = 1'b1;
        used_d = '0;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
    ctl.op = commit ? op_sel : kct_pkg::CELL_HOLD;
  end

  assign used_ext = {{kct_pkg::USED_W{1'b0}}, used_d};

  // ---- state, occupancy and result register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      rkey_q      <= '0;
      rcnt_q      <= '0;
      eu_q        <= '0;
      req_type_q  <= '0;
      key_q       <= '0;
      amount_q    <= '0;
    end else begin
      // a new result beat wins over draining the old one
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            req_type_q <= req_type_i;
            key_q      <= item_key_i;
            amount_q   <= amount_i;
            state_q    <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (commit) begin
            used_q      <= used_d;
            ok_q        <= ok_d;
            rkey_q      <= rkey_d;
            rcnt_q      <= rcnt_d;
            eu_q        <= used_ext[kct_pkg::USED_W-1:0];
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign ok_o           = ok_q;
  assign result_key_o   = rkey_q;
  assign result_count_o = rcnt_q;
  assign entries_used_o = eu_q;

`ifndef NO_ASSERTIONS
  // lookup never selects more than one cell
  a_sel_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(sel_vec))
    else $error("more than one cell selected");

  // occupancy stays within the table
  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  // a result appears only out of an apply cycle
  a_out_from_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_APPLY))
    else $error("result without apply");

  // an accepted beat always moves to apply
  a_accept_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_APPLY))
    else $error("accept did not start apply");
`endif

endmodule

`default_nettype wire

// ===== tb/keyed_count_table_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench for keyed_count_table_top: drives table requests through a shadow
// copy of the key/count table and checks every response beat against it.
// Depends on kct_pkg and the keyed_count_table_top RTL.

module keyed_count_table_top_tb;

  localparam int CAP         = 16;
  localparam int POOL_SIZE   = 24;
  localparam int STALL_LIMIT = 2000;  // cycles with no beat on either side
  localparam int TAIL_CYCLES = 8;     // settle time after the last response

  // request codes above clear are undefined and must be refused
  localparam logic [kct_pkg::REQ_W-1:0] REQ_UNUSED_FIRST = kct_pkg::REQ_CLEAR + 4'd1;
  localparam logic [kct_pkg::REQ_W-1:0] REQ_UNUSED_LAST  = 4'hF;

  typedef struct packed {
    logic                       ok;
    logic [kct_pkg::KEY_W-1:0]  key;
    logic [kct_pkg::DATA_W-1:0] count;
    logic [kct_pkg::USED_W-1:0] used;
  } reply_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic [kct_pkg::REQ_W-1:0]  req_type_i = '0;
  logic [kct_pkg::KEY_W-1:0]  item_key_i = '0;
  logic [kct_pkg::DATA_W-1:0] amount_i = '0;
  logic [kct_pkg::POS_W-1:0]  position_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic                       ok_o;
  logic [kct_pkg::KEY_W-1:0]  result_key_o;
  logic [kct_pkg::DATA_W-1:0] result_count_o;
  logic [kct_pkg::USED_W-1:0] entries_used_o;

  // shadow table, updated at every accepted request beat
  logic [kct_pkg::KEY_W-1:0]  tbl_key [CAP];
  logic [kct_pkg::DATA_W-1:0] tbl_count [CAP];
  int                         tbl_used = 0;
  reply_t                     replies_due[$];
  logic [kct_pkg::KEY_W-1:0]  key_pool [POOL_SIZE];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int err_cnt = 0;

  keyed_count_table_top #(.CAPACITY(CAP)) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .item_key_i    (item_key_i),
    .amount_i      (amount_i),
    .position_i    (position_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .ok_o          (ok_o),
    .result_key_o  (result_key_o),
    .result_count_o(result_count_o),
    .entries_used_o(entries_used_o)
  );

  initial begin : clock_gen
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shadow table
  // ---------------------------------------------------------------------------

  // newest matching entry, or CAP on a miss
  function automatic int slot_of(logic [kct_pkg::KEY_W-1:0] key);
    int i;
    for (i = 0; i < tbl_used; i++)
      if (tbl_key[i] == key) return i;
    return CAP;
  endfunction

  function automatic logic [kct_pkg::DATA_W-1:0] sat_sum(logic [kct_pkg::DATA_W-1:0] a,
                                                         logic [kct_pkg::DATA_W-1:0] b);
    logic [kct_pkg::DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[kct_pkg::DATA_W] ? '1 : s[kct_pkg::DATA_W-1:0];
  endfunction

  // close the gap left by the entry at p; later entries move up one
  function automatic void drop_slot(int p);
    int i;
    for (i = p; i + 1 < tbl_used; i++) begin
      tbl_key[i]   = tbl_key[i + 1];
      tbl_count[i] = tbl_count[i + 1];
    end
    tbl_used--;
  endfunction

  // apply one accepted request to the shadow and queue the response it owes
  function automatic void apply_request(logic [kct_pkg::REQ_W-1:0]  req,
                                        logic [kct_pkg::KEY_W-1:0]  key,
                                        logic [kct_pkg::DATA_W-1:0] amt,
                                        logic [kct_pkg::POS_W-1:0]  pos);
    reply_t r;
    int     hit;
    int     i;
    r   = '0;
    hit = slot_of(key);
    case (req)
      kct_pkg::REQ_ADD: begin
        // full table refuses even a key that is already present
        if (tbl_used < CAP) begin
          if (hit < CAP) begin
            tbl_count[hit] = sat_sum(tbl_count[hit], amt);
          end else begin
            for (i = tbl_used; i > 0; i--) begin
              tbl_key[i]   = tbl_key[i - 1];
              tbl_count[i] = tbl_count[i - 1];
            end
            tbl_key[0]   = key;
            tbl_count[0] = amt;
            tbl_used++;
          end
          r.ok = 1'b1;
        end
      end
      kct_pkg::REQ_RM_KEY: begin
        if (hit < CAP) begin
          drop_slot(hit);
          r.ok = 1'b1;
        end
      end
      kct_pkg::REQ_RM_POS: begin
        if (int'(pos) < tbl_used) begin
          drop_slot(int'(pos));
          r.ok = 1'b1;
        end
      end
      kct_pkg::REQ_GET_KEY: begin
        if (hit < CAP) begin
          r.key   = tbl_key[hit];
          r.count = tbl_count[hit];
          r.ok    = 1'b1;
        end
      end
      kct_pkg::REQ_GET_POS: begin
        if (int'(pos) < tbl_used) begin
          r.key   = tbl_key[pos];
          r.count = tbl_count[pos];
          r.ok    = 1'b1;
        end
      end
      kct_pkg::REQ_FIND: r.ok = (hit < CAP);
      kct_pkg::REQ_INCREASE: begin
        if (hit < CAP) begin
          tbl_count[hit] = sat_sum(tbl_count[hit], amt);
          r.ok = 1'b1;
        end
      end
      kct_pkg::REQ_DECREASE: begin
        // reaching zero drops the entry, including zero minus zero
        if (hit < CAP && tbl_count[hit] >= amt) begin
          tbl_count[hit] = tbl_count[hit] - amt;
          if (tbl_count[hit] == '0) drop_slot(hit);
          r.ok = 1'b1;
        end
      end
      kct_pkg::REQ_CLEAR: begin
        tbl_used = 0;
        r.ok     = 1'b1;
      end
      default: ;
    endcase
    r.used = kct_pkg::USED_W'(tbl_used);
    replies_due.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // One request beat. Valid is left high on return so back-to-back beats
  // never see a low/high pair in one step; it drops only ahead of a gap.
  task automatic send_req(logic [kct_pkg::REQ_W-1:0]  req,
                          logic [kct_pkg::KEY_W-1:0]  key,
                          logic [kct_pkg::DATA_W-1:0] amt,
                          logic [kct_pkg::POS_W-1:0]  pos);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    item_key_i <= key;
    amount_i   <= amt;
    position_i <= pos;
    do @(posedge clk_i); while (!in_ready_o);
    apply_request(req, key, amt, pos);
  endtask

  // hold off the sender until every queued response has come back
  task automatic drain_replies();
    in_valid_i <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Response side: random stall plus in-order compare
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : check_replies
    reply_t want;
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    if (out_valid_o && out_ready_i) begin
      if (replies_due.size() == 0) begin
        $error("response beat with nothing outstanding");
        err_cnt++;
      end else begin
        want = replies_due.pop_front();
        if (ok_o !== want.ok) begin
          $error("ok: expected %0h, got %0h", want.ok, ok_o);
          err_cnt++;
        end
        if (result_key_o !== want.key) begin
          $error("result_key: expected %0h, got %0h", want.key, result_key_o);
          err_cnt++;
        end
        if (result_count_o !== want.count) begin
          $error("result_count: expected %0h, got %0h", want.count, result_count_o);
          err_cnt++;
        end
        if (entries_used_o !== want.used) begin
          $error("entries_used: expected %0d, got %0d", want.used, entries_used_o);
          err_cnt++;
        end
      end
    end
  end

  // ends the run if neither side moves a beat for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("keyed_count_table_top_tb: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // empty-table behavior, field extremes, saturation, zero-count removal,
  // misses, out-of-range positions and undefined request codes
  task automatic test_directed_corners();
    send_req(kct_pkg::REQ_CLEAR, '0, '0, '0);
    send_req(kct_pkg::REQ_GET_POS, 16'hFFFF, 16'hFFFF, 4'hF);  // empty table: miss
    send_req(kct_pkg::REQ_RM_POS, '0, '0, '0);
    send_req(kct_pkg::REQ_FIND, '0, '0, '0);
    send_req(kct_pkg::REQ_ADD, 16'h0000, 16'h0000, '0);        // entry with count zero
    send_req(kct_pkg::REQ_DECREASE, 16'h0000, 16'h0000, '0);   // zero minus zero drops it
    send_req(kct_pkg::REQ_ADD, 16'hFFFF, 16'hFFFF, '0);
    send_req(kct_pkg::REQ_ADD, 16'hFFFF, 16'h0001, '0);        // add saturates
    send_req(kct_pkg::REQ_INCREASE, 16'hFFFF, 16'hFFFF, '0);   // increase saturates
    send_req(kct_pkg::REQ_INCREASE, 16'h1234, 16'h0001, '0);   // missing key
    send_req(kct_pkg::REQ_ADD, 16'h0001, 16'h0005, '0);
    send_req(kct_pkg::REQ_DECREASE, 16'h0001, 16'h0006, '0);   // short: refused
    send_req(kct_pkg::REQ_GET_POS, '0, '0, 4'd1);
    send_req(kct_pkg::REQ_DECREASE, 16'h0001, 16'h0005, '0);   // exact: removed
    send_req(kct_pkg::REQ_GET_KEY, 16'hFFFF, '0, '0);
    send_req(kct_pkg::REQ_GET_KEY, 16'h5555, '0, '0);
    send_req(kct_pkg::REQ_GET_POS, '0, '0, 4'd1);              // just past the end
    send_req(REQ_UNUSED_FIRST, 16'hFFFF, 16'hFFFF, 4'hF);
    send_req(REQ_UNUSED_LAST, 16'hFFFF, 16'hFFFF, 4'hF);
    send_req(kct_pkg::REQ_RM_KEY, 16'hFFFF, '0, '0);
    send_req(kct_pkg::REQ_RM_KEY, 16'hFFFF, '0, '0);           // already gone
  endtask

  // fill every slot, then check that adds are refused, and exercise the last slot
  task automatic test_full_table();
    int                        i;
    logic [kct_pkg::KEY_W-1:0] fresh;
    send_req(kct_pkg::REQ_CLEAR, '0, '0, '0);
    for (i = 0; i < CAP; i++)
      send_req(kct_pkg::REQ_ADD, {12'($urandom), 4'(i)}, 16'($urandom), '0);
    send_req(kct_pkg::REQ_ADD, tbl_key[3], 16'h0001, '0);      // present key, still refused
    do fresh = 16'($urandom); while (slot_of(fresh) < CAP);
    send_req(kct_pkg::REQ_ADD, fresh, 16'h0001, '0);
    send_req(kct_pkg::REQ_GET_POS, '0, '0, 4'hF);
    send_req(kct_pkg::REQ_RM_POS, '0, '0, 4'hF);
    send_req(kct_pkg::REQ_RM_POS, '0, '0, 4'hF);               // now out of range
  endtask

  function automatic logic [kct_pkg::KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 50 && tbl_used > 0) return tbl_key[$urandom_range(tbl_used - 1)];
    if (r < 80) return key_pool[$urandom_range(POOL_SIZE - 1)];
    return 16'($urandom);
  endfunction

  function automatic logic [kct_pkg::DATA_W-1:0] pick_amount(logic [kct_pkg::REQ_W-1:0] req,
                                                             logic [kct_pkg::KEY_W-1:0] key);
    int r;
    int hit;
    r   = $urandom_range(99);
    hit = slot_of(key);
    if (req == kct_pkg::REQ_DECREASE && hit < CAP && r < 40) return tbl_count[hit];
    if (r < 30) return 16'($urandom_range(3));
    if (r < 40) return 16'hFFFF;
    if (r < 50) return '0;
    return 16'($urandom);
  endfunction

  function automatic logic [kct_pkg::REQ_W-1:0] REQ_LAST_PICK();
    return kct_pkg::REQ_W'($urandom_range(REQ_UNUSED_LAST, REQ_UNUSED_FIRST));
  endfunction

  function automatic logic [kct_pkg::REQ_W-1:0] pick_req();
    int w;
    w = $urandom_range(99);
    if (w < 30) return kct_pkg::REQ_ADD;
    if (w < 36) return kct_pkg::REQ_RM_KEY;
    if (w < 41) return kct_pkg::REQ_RM_POS;
    if (w < 49) return kct_pkg::REQ_GET_KEY;
    if (w < 56) return kct_pkg::REQ_GET_POS;
    if (w < 63) return kct_pkg::REQ_FIND;
    if (w < 73) return kct_pkg::REQ_INCREASE;
    if (w < 90) return kct_pkg::REQ_DECREASE;
    if (w < 92) return kct_pkg::REQ_CLEAR;
    if (w < 95) return REQ_LAST_PICK();
    return kct_pkg::REQ_ADD;
  endfunction

  // Keys mostly come from the table or a small pool so hits, growth to a
  // full table and removals are frequent; a share is fully random.
  task automatic test_random_mix(int n_items);
    int                         i;
    logic [kct_pkg::REQ_W-1:0]  req;
    logic [kct_pkg::KEY_W-1:0]  key;
    logic [kct_pkg::DATA_W-1:0] amt;
    logic [kct_pkg::POS_W-1:0]  pos;
    for (i = 0; i < POOL_SIZE; i++) key_pool[i] = 16'($urandom);
    for (i = 0; i < n_items; i++) begin
      req = pick_req();
      key = pick_key();
      amt = pick_amount(req, key);
      if (tbl_used > 0 && $urandom_range(99) < 70)
        pos = kct_pkg::POS_W'($urandom_range(tbl_used));
      else
        pos = kct_pkg::POS_W'($urandom);
      send_req(req, key, amt, pos);
      if (i == n_items / 2) drain_replies();
    end
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin : main_seq
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_corners();
    test_full_table();

    set_idling(0, 0);
    test_random_mix(475);
    set_idling(77, 0);
    test_random_mix(475);
    set_idling(0, 77);
    test_random_mix(475);
    set_idling(28, 28);
    test_random_mix(475);

    drain_replies();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0)
      $display("keyed_count_table_top_tb: clean");
    else
      $display("keyed_count_table_top_tb: errors");
    $finish;
  end

endmodule
